// File: design/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants of the multiplexed range-sensor reader.
// ----------------------------------------------------------------------------
package msr_pkg;

  // Widths of the external channels.
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ENABLE_W    = 8;

  // Frame format.
  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  // Input item kinds.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_BYTE   = 2'd3
  } cmd_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_DIST     = 3'd0,
    EV_SELECTED = 3'd1,
    EV_BAD_ID   = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_BUSY     = 3'd4
  } event_t;

  // Select sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOWN   = 2'd1,
    PH_SETTLE = 2'd2,
    PH_UP     = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SENSORS_IN_USE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_PIN_PRESENT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_POLARITY_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_DOWN_MS      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_SETTLE_MS     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_UP_MS        = 3'd5;

  // Configuration register file contents.
  typedef struct packed {
    logic [3:0]  sensors_in_use;
    logic        mode_pin_present;
    logic        mode_polarity_high;
    logic [15:0] power_down_ms;
    logic [15:0] mode_settle_ms;
    logic [15:0] power_up_ms;
  } cfg_t;

  // One decoded input item.
  typedef struct packed {
    cmd_t        command;
    logic [3:0]  sensor_index;
    logic        processed_mode;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    event_t              event_code;
    logic [15:0]         distance_value;
    logic [ENABLE_W-1:0] enable_lines;
    logic                mode_level;
  } result_t;

endpackage

// File: design/msr_cfg_regs.sv
// ----------------------------------------------------------------------------
// msr_cfg_regs
// Configuration register file written through a plain index/data port.
// ----------------------------------------------------------------------------
module msr_cfg_regs
  import msr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensors_in_use     <= 4'd1;
      cfg_r.mode_pin_present   <= 1'b0;
      cfg_r.mode_polarity_high <= 1'b1;
      cfg_r.power_down_ms      <= 16'd10;
      cfg_r.mode_settle_ms     <= 16'd2;
      cfg_r.power_up_ms        <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SENSORS_IN_USE:     cfg_r.sensors_in_use     <= cfg_wdata[3:0];
        REG_MODE_PIN_PRESENT:   cfg_r.mode_pin_present   <= cfg_wdata[0];
        REG_MODE_POLARITY_HIGH: cfg_r.mode_polarity_high <= cfg_wdata[0];
        REG_POWER_DOWN_MS:      cfg_r.power_down_ms      <= cfg_wdata;
        REG_MODE_SETTLE_MS:     cfg_r.mode_settle_ms     <= cfg_wdata;
        REG_POWER_UP_MS:        cfg_r.power_up_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/msr_core.sv
// ----------------------------------------------------------------------------
// msr_core
// Select sequencer, read timer and frame parser; one item per enabled cycle.
// ----------------------------------------------------------------------------
module msr_core
  import msr_pkg::*;
#(
  parameter int MAX_SENSORS = 8
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  // Sensors that can be addressed at all: the parameter, capped by the enable width.
  localparam int          LIMIT     = (MAX_SENSORS < ENABLE_W) ? MAX_SENSORS : ENABLE_W;
  localparam logic [3:0]  LIMIT_CNT = 4'(LIMIT);

  phase_t              phase_r, phase_nxt;
  logic [15:0]         phase_timer_r, phase_timer_nxt;
  logic [ENABLE_W-1:0] enable_r, enable_nxt;
  logic                mode_r, mode_nxt;
  logic [2:0]          pend_idx_r, pend_idx_nxt;
  logic                pend_mode_r, pend_mode_nxt;
  logic                read_active_r, read_active_nxt;
  logic [15:0]         read_timer_r, read_timer_nxt;
  logic [1:0]          fpos_r, fpos_nxt;
  logic [7:0]          fb0_r, fb0_nxt;
  logic [7:0]          fb1_r, fb1_nxt;
  logic [7:0]          fb2_r, fb2_nxt;

  logic        busy;
  logic [3:0]  usable;
  logic [15:0] phase_dec;
  logic [15:0] read_dec;
  logic [7:0]  frame_sum;
  event_t      ev;
  logic [15:0] dist_val;

  assign busy      = (phase_r != PH_IDLE) || read_active_r;
  assign usable    = (cfg.sensors_in_use > LIMIT_CNT) ? LIMIT_CNT : cfg.sensors_in_use;
  assign phase_dec = (phase_timer_r != 16'd0) ? phase_timer_r - 16'd1 : 16'd0;
  assign read_dec  = (read_timer_r != 16'd0) ? read_timer_r - 16'd1 : 16'd0;
  assign frame_sum = fb0_r + fb1_r + fb2_r;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt       = phase_r;
    phase_timer_nxt = phase_timer_r;
    enable_nxt      = enable_r;
    mode_nxt        = mode_r;
    pend_idx_nxt    = pend_idx_r;
    pend_mode_nxt   = pend_mode_r;
    read_active_nxt = read_active_r;
    read_timer_nxt  = read_timer_r;
    fpos_nxt        = fpos_r;
    fb0_nxt         = fb0_r;
    fb1_nxt         = fb1_r;
    fb2_nxt         = fb2_r;
    res_valid       = 1'b0;
    ev              = EV_DIST;
    dist_val        = 16'd0;

    case (item.command)
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          // A phase ends on the tick that leaves its timer at zero.
          phase_timer_nxt = phase_dec;
          if (phase_dec == 16'd0) begin
            case (phase_r)
              PH_DOWN: begin
                if (cfg.mode_pin_present) begin
                  mode_nxt = cfg.mode_polarity_high ? pend_mode_r : ~pend_mode_r;
                end
                phase_timer_nxt = cfg.mode_settle_ms;
                phase_nxt       = PH_SETTLE;
              end
              PH_SETTLE: begin
                enable_nxt      = ENABLE_W'(1) << pend_idx_r;
                phase_timer_nxt = cfg.power_up_ms;
                phase_nxt       = PH_UP;
              end
              PH_UP: begin
                fpos_nxt  = 2'd0;
                phase_nxt = PH_IDLE;
                res_valid = 1'b1;
                ev        = EV_SELECTED;
              end
              default: ;
            endcase
          end
        end else if (read_active_r) begin
          read_timer_nxt = read_dec;
          if (read_dec == 16'd0) begin
            read_active_nxt = 1'b0;
            fpos_nxt        = 2'd0;
            res_valid       = 1'b1;
            ev              = EV_TIMEOUT;
          end
        end
      end

      CMD_SELECT: begin
        if (busy) begin
          res_valid = 1'b1;
          ev        = EV_BUSY;
        end else if (item.sensor_index >= usable) begin
          res_valid = 1'b1;
          ev        = EV_BAD_ID;
        end else begin
          pend_idx_nxt    = item.sensor_index[2:0];
          pend_mode_nxt   = item.processed_mode;
          enable_nxt      = '0;
          phase_timer_nxt = cfg.power_down_ms;
          phase_nxt       = PH_DOWN;
        end
      end

      CMD_READ: begin
        if (busy) begin
          res_valid = 1'b1;
          ev        = EV_BUSY;
        end else begin
          fpos_nxt = 2'd0;
          if (item.timeout_ticks == 16'd0) begin
            res_valid = 1'b1;
            ev        = EV_TIMEOUT;
          end else begin
            read_timer_nxt  = item.timeout_ticks;
            read_active_nxt = 1'b1;
          end
        end
      end

      CMD_BYTE: begin
        // Bytes outside an active read are dropped.
        if (read_active_r) begin
          case (fpos_r)
            2'd0: begin
              if (item.rx_byte == HEADER_BYTE) begin
                fb0_nxt  = item.rx_byte;
                fpos_nxt = 2'd1;
              end
            end
            2'd1: begin
              fb1_nxt  = item.rx_byte;
              fpos_nxt = 2'd2;
            end
            2'd2: begin
              fb2_nxt  = item.rx_byte;
              fpos_nxt = 2'd3;
            end
            default: begin
              // Checksum byte: a mismatch just restarts the header hunt.
              fpos_nxt = 2'd0;
              if (frame_sum == item.rx_byte) begin
                read_active_nxt = 1'b0;
                read_timer_nxt  = 16'd0;
                res_valid       = 1'b1;
                ev              = EV_DIST;
                dist_val        = {fb1_r, fb2_r};
              end
            end
          endcase
        end
      end

      default: ;
    endcase
  end

  // Result carries the pin levels as they stand after the item.
  always_comb begin
    res.event_code     = ev;
    res.distance_value = dist_val;
    res.enable_lines   = enable_nxt;
    res.mode_level     = mode_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_timer_r <= 16'd0;
      enable_r      <= '0;
      mode_r        <= 1'b0;
      pend_idx_r    <= 3'd0;
      pend_mode_r   <= 1'b0;
      read_active_r <= 1'b0;
      read_timer_r  <= 16'd0;
      fpos_r        <= 2'd0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      phase_timer_r <= phase_timer_nxt;
      enable_r      <= enable_nxt;
      mode_r        <= mode_nxt;
      pend_idx_r    <= pend_idx_nxt;
      pend_mode_r   <= pend_mode_nxt;
      read_active_r <= read_active_nxt;
      read_timer_r  <= read_timer_nxt;
      fpos_r        <= fpos_nxt;
    end
  end

  // Frame bytes are always written before they are read.
  always_ff @(posedge clk) begin
    if (step_en) begin
      fb0_r <= fb0_nxt;
      fb1_r <= fb1_nxt;
      fb2_r <= fb2_nxt;
    end
  end

endmodule

// File: design/muxed_range_sensor_reader.sv
// ----------------------------------------------------------------------------
// muxed_range_sensor_reader
// Sequencer and serial frame parser for multiplexed ultrasonic range sensors.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is not stalled:
// an item is captured in the input register, decoded by the core logic and
// its result, if any, is held in the output register until taken. The input
// side stalls only when the output register holds a result that the
// downstream side has not yet taken. Select and read timing count tick items,
// not clock cycles; every other item kind finishes in its own cycle.
// Configuration takes effect at the next item.
module muxed_range_sensor_reader
  import msr_pkg::*;
#(
  parameter int MAX_SENSORS = 8
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] sensor_index, [4] processed_mode, [20:5] timeout_ticks, [28:21] rx_byte
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] distance_value, [23:16] enable_lines, [24] mode_level
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] event_code
  output logic [OUT_TUSER_W-1:0] out_tuser,
  // Configuration port.
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  logic    out_free;
  logic    step_en;
  logic    res_valid;
  result_t res;
  result_t out_res_r;
  logic    out_vld_r;

  msr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage handshake: the captured item is processed when the output slot is free.
  assign out_free  = !out_vld_r || out_tready;
  assign step_en   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || step_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command        <= cmd_t'(in_tuser[1:0]);
      item_r.sensor_index   <= in_tdata[3:0];
      item_r.processed_mode <= in_tdata[4];
      item_r.timeout_ticks  <= in_tdata[20:5];
      item_r.rx_byte        <= in_tdata[28:21];
    end
  end

  msr_core #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en) begin
      out_vld_r <= res_valid;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.event_code;
  assign out_tdata  = {7'd0, out_res_r.mode_level, out_res_r.enable_lines,
                       out_res_r.distance_value};

`ifndef SYNTHESIS
  // At most one sensor is ever powered.
  a_enable_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[23:16]))
    else $error("more than one sensor enable is on");

  // Only a distance result carries a nonzero distance.
  a_dist_only_with_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != EV_DIST) |-> (out_tdata[15:0] == 16'd0))
    else $error("distance set on a non-distance result");

  // A pending result that is not taken blocks the core step.
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_tready) |=> in_vld_r)
    else $error("captured item lost while the output was stalled");

  // Event codes stay in the defined set.
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == EV_DIST || out_tuser == EV_SELECTED ||
                    out_tuser == EV_BAD_ID || out_tuser == EV_TIMEOUT ||
                    out_tuser == EV_BUSY))
    else $error("undefined event code on output");
`endif

endmodule
